FILE: design/nlv_pkg.sv
// Shared types and constants for the neighbor list block.
package nlv_pkg;

  // Default sizes
  localparam int CAPACITY_DEF   = 16;
  localparam int VALUE_BITS_DEF = 16;

  // Result limits
  localparam int SUM_MAX   = 524287;
  localparam int SUM_MIN   = -524288;
  localparam int COUNT_MAX = 31;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_ZERO_ID   = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e               command;
    logic [7:0]         entry_id;
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;
  } request_t;

  typedef struct packed {
    status_e            status;
    logic               is_present;
    logic [4:0]         entry_count;
    logic signed [19:0] sum_x;
    logic signed [19:0] sum_y;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_APPLY,
    S_RESULT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic rd_en;
    logic rd_next;
    logic mark_found;
    logic idx_inc;
    logic wr_shift;
    logic apply;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_end;
    logic hit;
    logic shift_end;
    logic is_remove;
  } ctrl_status_t;

endpackage

FILE: design/nlv_ctrl.sv
// Sequencer for scan, shift and commit of one request.
module nlv_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  nlv_pkg::ctrl_status_t st,
  output nlv_pkg::ctrl_cmd_t    cmd,
  output logic                  busy,
  output logic                  done
);
  import nlv_pkg::*;

  state_e state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (st.scan_end) begin
          state_next = S_APPLY;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (st.hit) begin
          cmd.mark_found = 1'b1;
          state_next     = st.is_remove ? S_SHIFT_RD : S_APPLY;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if (st.shift_end) begin
          state_next = S_APPLY;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
          state_next  = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_RESULT);

endmodule

FILE: design/nlv_datapath.sv
// Entry memory, scan index, count and running sums.
module nlv_datapath #(
  parameter int CAPACITY   = nlv_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = nlv_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  nlv_pkg::request_t     request,
  input  nlv_pkg::ctrl_cmd_t    cmd,
  output nlv_pkg::ctrl_status_t st,
  output nlv_pkg::result_t      result
);
  import nlv_pkg::*;

  localparam int KEEP_BITS = (VALUE_BITS < 16) ? VALUE_BITS : 16;
  localparam int AW        = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int SUM_W     = KEEP_BITS + $clog2(CAPACITY) + 1;
  localparam int CW        = SUM_W + 20;
  localparam int OW        = CNT_W + 5;

  localparam logic signed [CW-1:0] LIM_HI = CW'(SUM_MAX);
  localparam logic signed [CW-1:0] LIM_LO = CW'(SUM_MIN);

  typedef struct packed {
    logic [7:0]                  id;
    logic signed [KEEP_BITS-1:0] x;
    logic signed [KEEP_BITS-1:0] y;
  } row_t;

  row_t                    mem [CAPACITY];
  row_t                    rdata;
  request_t                req;
  logic [CNT_W-1:0]        idx;
  logic [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic                    found;
  logic signed [KEEP_BITS-1:0] rem_x;
  logic signed [KEEP_BITS-1:0] rem_y;
  status_e                 status_q;

  logic signed [KEEP_BITS-1:0] keep_x;
  logic signed [KEEP_BITS-1:0] keep_y;
  logic [CNT_W:0]          idx_p1;
  logic [AW-1:0]           raddr;
  logic                    we;
  logic [AW-1:0]           waddr;
  row_t                    wdata;
  logic                    zero_id;
  logic                    is_full;
  logic                    add_ok;

  assign keep_x  = req.in_x[KEEP_BITS-1:0];
  assign keep_y  = req.in_y[KEEP_BITS-1:0];
  assign idx_p1  = {1'b0, idx} + (CNT_W + 1)'(1);
  assign zero_id = (req.entry_id == 8'd0);
  assign is_full = (count >= CNT_W'(CAPACITY));
  assign add_ok  = cmd.apply && (req.command == CMD_ADD) && !zero_id && !is_full;

  // Status toward the controller
  assign st.scan_end  = zero_id || (idx >= count);
  assign st.hit       = (rdata.id == req.entry_id);
  assign st.shift_end = (idx_p1 >= {1'b0, count});
  assign st.is_remove = (req.command == CMD_REMOVE);

  // Pick read and write addresses
  assign raddr = cmd.rd_next ? idx_p1[AW-1:0] : idx[AW-1:0];
  assign we    = cmd.wr_shift || add_ok;
  assign waddr = cmd.wr_shift ? idx[AW-1:0] : count[AW-1:0];
  always_comb begin
    if (cmd.wr_shift) begin
      wdata = rdata;
    end else begin
      wdata.id = req.entry_id;
      wdata.x  = keep_x;
      wdata.y  = keep_y;
    end
  end

  // Entry memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // Latch request, step index, remember match
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req   <= request;
      idx   <= '0;
      found <= 1'b0;
    end else if (cmd.mark_found) begin
      found <= 1'b1;
      rem_x <= rdata.x;
      rem_y <= rdata.y;
    end else if (cmd.idx_inc || cmd.wr_shift) begin
      idx <= idx_p1[CNT_W-1:0];
    end
  end

  // Commit the request to count, sums and status
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum_x <= '0;
      sum_y <= '0;
    end else if (cmd.apply) begin
      if (req.command == CMD_CLEAR) begin
        status_q <= ST_OK;
        count    <= '0;
        sum_x    <= '0;
        sum_y    <= '0;
      end else if (zero_id) begin
        status_q <= ST_ZERO_ID;
      end else begin
        unique case (req.command)
          CMD_ADD: begin
            if (is_full) begin
              status_q <= ST_FULL;
            end else begin
              status_q <= ST_OK;
              count    <= count + CNT_W'(1);
              sum_x    <= sum_x + SUM_W'(keep_x);
              sum_y    <= sum_y + SUM_W'(keep_y);
            end
          end
          CMD_REMOVE: begin
            if (!found) begin
              status_q <= ST_NOT_FOUND;
            end else begin
              status_q <= ST_OK;
              count    <= count - CNT_W'(1);
              sum_x    <= sum_x - SUM_W'(rem_x);
              sum_y    <= sum_y - SUM_W'(rem_y);
            end
          end
          CMD_LOOKUP: begin
            status_q <= found ? ST_OK : ST_NOT_FOUND;
          end
          CMD_CLEAR: begin
            status_q <= ST_OK;
          end
          default: begin
            status_q <= ST_OK;
          end
        endcase
      end
    end
  end

  // Saturate reported values
  logic signed [CW-1:0] wide_x;
  logic signed [CW-1:0] wide_y;
  logic [OW-1:0]        cnt_wide;

  assign wide_x   = CW'(sum_x);
  assign wide_y   = CW'(sum_y);
  assign cnt_wide = OW'(count);

  always_comb begin
    result.status      = status_q;
    result.is_present  = found;
    result.entry_count = (cnt_wide > OW'(COUNT_MAX)) ? 5'(COUNT_MAX) : cnt_wide[4:0];
    if (wide_x > LIM_HI) begin
      result.sum_x = 20'(SUM_MAX);
    end else if (wide_x < LIM_LO) begin
      result.sum_x = 20'(SUM_MIN);
    end else begin
      result.sum_x = wide_x[19:0];
    end
    if (wide_y > LIM_HI) begin
      result.sum_y = 20'(SUM_MAX);
    end else if (wide_y < LIM_LO) begin
      result.sum_y = 20'(SUM_MIN);
    end else begin
      result.sum_y = wide_y[19:0];
    end
  end

endmodule

FILE: design/neighbor_list_with_values_core.sv
// Top level of the packed neighbor list with per-entry x and y values.
//
// Request channel: drive request and raise start; the request is taken at a
// clock edge where start is high and busy is low. Commands are add (append at
// the first free slot), remove (delete first match, shift later entries down),
// lookup and clear. Entry id zero is rejected for all but clear.
// Result channel: done is high for exactly one cycle while result holds the
// status, membership flag, entry count and saturated x and y sums. The
// receiver has no way to stall; it must take the result in that cycle.
// Sequencing: entries are kept in a memory with one read and one write port,
// visited one at a time. The scan reads each entry (address, then compare)
// until a match or the end of the list; a remove then shifts each later entry
// down with a read and a write. The request is taken in the idle state, and
// the commit and result states close it.
// busy stays high from the accepted request through the done cycle.
// Reset empties the list and zeroes the sums at once; no clearing pass.
module neighbor_list_with_values_core #(
  parameter int CAPACITY   = nlv_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = nlv_pkg::VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  nlv_pkg::request_t request,
  output logic              busy,
  output logic              done,
  output nlv_pkg::result_t  result
);
  import nlv_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t st;

  // Sequencer
  nlv_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Storage and arithmetic
  nlv_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .st      (st),
    .result  (result)
  );

endmodule

FILE: design/nlv_checker.sv
// Port-level checks for the neighbor list core, bound to the top level.
module nlv_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input nlv_pkg::result_t  result
);
  import nlv_pkg::*;

  // Accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // Result strobe lasts a single cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  // Result appears only while a request is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done without busy");

  // Block is ready after the result
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("block still busy after result");

  // Rejected zero id never reports membership
  a_zero_absent: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_ZERO_ID)) |-> !result.is_present)
    else $error("zero id reported as present");

endmodule

bind neighbor_list_with_values_core nlv_checker u_nlv_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .result  (result)
);
